/* rtl/hfsd_pkg.sv */
// Package for the heightfield span direction flags unit.
// Holds the input and result word types, the span entry type and the fixed codes.
// No dependencies.
package hfsd_pkg;

  // Opcodes of an input word.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_CLEARANCE   = 3'd2;
  localparam logic [2:0] CFG_STEEP_LIMIT = 3'd3;
  localparam logic [2:0] CFG_FLAT_LIMIT  = 3'd4;

  // Class bits of a span.
  localparam logic [1:0] CLS_NULL  = 2'd0;
  localparam int         CLS_STEEP_BIT = 1;

  // Free space above the last span of a column reaches this height.
  localparam logic [15:0] TOP_LIMIT = 16'hffff;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [12:0] span_floor_start;
    logic [12:0] span_floor_end;
    logic [1:0]  span_kind;
  } in_word_t;

  typedef struct packed {
    logic [5:0] out_x;
    logic [5:0] out_y;
    logic [2:0] slot;
    logic [5:0] span_flags;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [12:0] start;
    logic [12:0] floor;
    logic [1:0]  cls;
  } span_entry_t;

endpackage

/* rtl/heightfield_span_direction_flags_unit.sv */
// Heightfield span store with per-span direction flags. A clear runs a pass over the column fill
// memory; the same pass runs after reset, during which no word is accepted. A query reads the
// column fill, then per span its own entry and, per direction, the neighbour spans in turn until
// one passes the clearance test or the last is walked; a direction at a grid edge is flagged
// without a read. Every step waits on a registered memory read. A result word waits while the
// output is stalled. One word is worked on at a time.
module heightfield_span_direction_flags_unit #(
  parameter int MAX_GRID_X = 64,
  parameter int MAX_GRID_Y = 64,
  parameter int MAX_SPANS  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hfsd_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hfsd_pkg::out_word_t  out_word,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int COLS  = MAX_GRID_X * MAX_GRID_Y;
  localparam int COLW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SLW   = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int FILLW = $clog2(MAX_SPANS + 1);
  localparam int DEPTH = COLS * MAX_SPANS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_LFILLW   = 4'd2;
  localparam logic [3:0] S_QFILLW   = 4'd3;
  localparam logic [3:0] S_OWN      = 4'd4;
  localparam logic [3:0] S_OWNW     = 4'd5;
  localparam logic [3:0] S_DIR      = 4'd6;
  localparam logic [3:0] S_NFILLW   = 4'd7;
  localparam logic [3:0] S_NSPAN    = 4'd8;
  localparam logic [3:0] S_NSPANW   = 4'd9;
  localparam logic [3:0] S_SPANDONE = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;
  localparam logic [3:0] S_CLR      = 4'd12;

  // Configuration registers.
  logic [6:0]  grid_width;
  logic [6:0]  grid_height;
  logic [15:0] clearance_needed;
  logic [12:0] steep_climb_limit;
  logic [12:0] flat_climb_limit;

  // Sequencer registers.
  logic [3:0]          state;
  hfsd_pkg::in_word_t  item;
  logic [FILLW-1:0]    n;
  logic [SLW-1:0]      i;
  logic [1:0]          d;
  logic [5:0]          flags;
  logic [12:0]         own_floor;
  logic [15:0]         own_top;
  logic [1:0]          own_cls;
  logic [FILLW-1:0]    nn;
  logic [SLW-1:0]      k;
  logic [COLW-1:0]     ncol;
  hfsd_pkg::out_word_t res;
  logic                res_more;
  logic [COLW-1:0]     clr_cnt;
  logic                clr_emit;

  // Column fill memory.
  logic [FILLW-1:0] fill_mem [COLS];
  logic [FILLW-1:0] fill_q;
  logic [COLW-1:0]  fill_raddr;
  logic             fill_we;
  logic [COLW-1:0]  fill_waddr;
  logic [FILLW-1:0] fill_wdata;

  // Span store ports.
  logic                  span_we;
  logic [AW-1:0]         span_waddr;
  hfsd_pkg::span_entry_t span_wdata;
  logic [AW-1:0]         span_raddr_a;
  logic [AW-1:0]         span_raddr_b;
  hfsd_pkg::span_entry_t span_a;
  hfsd_pkg::span_entry_t span_b;

  // Combinational helpers.
  logic             in_grid;
  logic [COLW-1:0]  col;
  logic             n_outside;
  logic [COLW-1:0]  ncol_c;
  logic             out_free;
  logic             emit;
  logic [15:0]      nt;
  logic             pass;
  logic             climb_ok;
  logic             last_span;
  logic             last_nspan;

  hfsd_span_mem #(.DEPTH(DEPTH), .AW(AW)) u_span_mem (
    .clk     (clk),
    .we      (span_we),
    .waddr   (span_waddr),
    .wdata   (span_wdata),
    .raddr_a (span_raddr_a),
    .raddr_b (span_raddr_b),
    .rdata_a (span_a),
    .rdata_b (span_b)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == S_EMIT) && out_free;

  // Column of the current word and whether it lies in the grid in use.
  always_comb begin
    in_grid = (32'(item.cell_x) < 32'(grid_width)) && (32'(item.cell_x) < MAX_GRID_X) &&
              (32'(item.cell_y) < 32'(grid_height)) && (32'(item.cell_y) < MAX_GRID_Y);
    col = COLW'(int'(item.cell_y) * MAX_GRID_X + int'(item.cell_x));
  end

  // Neighbour column for the current direction.
  always_comb begin
    int nx;
    int ny;
    nx = int'(item.cell_x);
    ny = int'(item.cell_y);
    case (d)
      2'd0:    nx = nx - 1;
      2'd1:    ny = ny + 1;
      2'd2:    nx = nx + 1;
      default: ny = ny - 1;
    endcase
    n_outside = (nx < 0) || (ny < 0) || (nx >= int'(grid_width)) || (nx >= MAX_GRID_X) ||
                (ny >= int'(grid_height)) || (ny >= MAX_GRID_Y);
    ncol_c = COLW'(ny * MAX_GRID_X + nx);
  end

  // Clearance and climb tests against the neighbour span just read.
  always_comb begin
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    logic signed [17:0] climb;
    logic signed [17:0] lim;
    last_nspan = (FILLW'(k) + FILLW'(1)) == nn;
    nt = ((FILLW'(k) + FILLW'(1)) < nn) ? {3'b000, span_b.start} : hfsd_pkg::TOP_LIMIT;
    hi = (own_top < nt) ? $signed({2'b00, own_top}) : $signed({2'b00, nt});
    lo = (own_floor > span_a.floor) ? $signed({5'b00000, own_floor})
                                    : $signed({5'b00000, span_a.floor});
    pass = (span_a.cls != hfsd_pkg::CLS_NULL) &&
           ((hi - lo) >= $signed({2'b00, clearance_needed}));
    climb = $signed({5'b00000, span_a.floor}) - $signed({5'b00000, own_floor});
    lim = (own_cls[hfsd_pkg::CLS_STEEP_BIT] || span_a.cls[hfsd_pkg::CLS_STEEP_BIT])
          ? $signed({5'b00000, steep_climb_limit}) : $signed({5'b00000, flat_climb_limit});
    climb_ok = climb <= lim;
    last_span = (FILLW'(i) + FILLW'(1)) == n;
  end

  // Memory address and write selection.
  always_comb begin
    fill_raddr   = (state == S_DIR) ? ncol_c : col;
    fill_we      = 1'b0;
    fill_waddr   = col;
    fill_wdata   = FILLW'(fill_q + FILLW'(1));
    span_we      = 1'b0;
    span_waddr   = AW'(int'(col) * MAX_SPANS + int'(fill_q));
    span_wdata.start = item.span_floor_start;
    span_wdata.floor = item.span_floor_end;
    span_wdata.cls   = item.span_kind;
    if (state == S_NSPAN) begin
      span_raddr_a = AW'(int'(ncol) * MAX_SPANS + int'(k));
      span_raddr_b = AW'(int'(ncol) * MAX_SPANS + int'(k) + 1);
    end else begin
      span_raddr_a = AW'(int'(col) * MAX_SPANS + int'(i));
      span_raddr_b = AW'(int'(col) * MAX_SPANS + int'(i) + 1);
    end
    if (state == S_CLR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt;
      fill_wdata = '0;
    end else if (state == S_LFILLW && 32'(fill_q) < MAX_SPANS) begin
      fill_we = 1'b1;
      span_we = 1'b1;
    end
  end

  // Column fill memory with registered read.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_q <= fill_mem[fill_raddr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width        <= 7'd64;
      grid_height       <= 7'd64;
      clearance_needed  <= 16'd16;
      steep_climb_limit <= 13'd2;
      flat_climb_limit  <= 13'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        hfsd_pkg::CFG_GRID_WIDTH:  grid_width        <= cfg_data[6:0];
        hfsd_pkg::CFG_GRID_HEIGHT: grid_height       <= cfg_data[6:0];
        hfsd_pkg::CFG_CLEARANCE:   clearance_needed  <= cfg_data;
        hfsd_pkg::CFG_STEEP_LIMIT: steep_climb_limit <= cfg_data[12:0];
        hfsd_pkg::CFG_FLAT_LIMIT:  flat_climb_limit  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Output word register: loaded when a result word is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_word  <= res;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      clr_emit  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_word;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          res      <= '0;
          res_more <= 1'b0;
          case (item.opcode)
            hfsd_pkg::OP_LOAD: begin
              if (in_grid) begin
                state <= S_LFILLW;
              end else begin
                res <= '{item.cell_x, item.cell_y, 3'd0, 6'd0, hfsd_pkg::ST_FULL, 1'b1};
                state <= S_EMIT;
              end
            end
            hfsd_pkg::OP_QUERY: begin
              if (in_grid) begin
                state <= S_QFILLW;
              end else begin
                res <= '{item.cell_x, item.cell_y, 3'd0, 6'd0, hfsd_pkg::ST_EMPTY, 1'b1};
                state <= S_EMIT;
              end
            end
            hfsd_pkg::OP_CLEAR: begin
              clr_cnt  <= '0;
              clr_emit <= 1'b1;
              state    <= S_CLR;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_LFILLW: begin
          if (32'(fill_q) < MAX_SPANS) begin
            res <= '{item.cell_x, item.cell_y, 3'(fill_q), 6'd0, hfsd_pkg::ST_OK, 1'b1};
          end else begin
            res <= '{item.cell_x, item.cell_y, 3'd0, 6'd0, hfsd_pkg::ST_FULL, 1'b1};
          end
          state <= S_EMIT;
        end
        S_QFILLW: begin
          n <= fill_q;
          i <= '0;
          if (fill_q == '0) begin
            res <= '{item.cell_x, item.cell_y, 3'd0, 6'd0, hfsd_pkg::ST_EMPTY, 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_OWN;
          end
        end
        S_OWN: state <= S_OWNW;
        S_OWNW: begin
          own_floor <= span_a.floor;
          own_cls   <= span_a.cls;
          own_top   <= ((FILLW'(i) + FILLW'(1)) < n) ? {3'b000, span_b.start}
                                                      : hfsd_pkg::TOP_LIMIT;
          d         <= 2'd0;
          flags     <= {4'b0000, span_a.cls};
          if (span_a.cls == hfsd_pkg::CLS_NULL) begin
            state <= S_SPANDONE;
          end else begin
            state <= S_DIR;
          end
        end
        S_DIR: begin
          ncol <= ncol_c;
          if (n_outside) begin
            flags[3'(d) + 3'd2] <= 1'b1;
            d     <= d + 2'd1;
            state <= (d == 2'd3) ? S_SPANDONE : S_DIR;
          end else begin
            state <= S_NFILLW;
          end
        end
        S_NFILLW: begin
          nn <= fill_q;
          k  <= '0;
          if (fill_q == '0) begin
            d     <= d + 2'd1;
            state <= (d == 2'd3) ? S_SPANDONE : S_DIR;
          end else begin
            state <= S_NSPAN;
          end
        end
        S_NSPAN: state <= S_NSPANW;
        S_NSPANW: begin
          if (pass || last_nspan) begin
            if (pass && climb_ok) begin
              flags[3'(d) + 3'd2] <= 1'b1;
            end
            d     <= d + 2'd1;
            state <= (d == 2'd3) ? S_SPANDONE : S_DIR;
          end else begin
            k     <= k + SLW'(1);
            state <= S_NSPAN;
          end
        end
        S_SPANDONE: begin
          res <= '{item.cell_x, item.cell_y, 3'(i), flags, hfsd_pkg::ST_OK, last_span};
          res_more <= !last_span;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (res_more) begin
              i     <= i + SLW'(1);
              state <= S_OWN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + COLW'(1);
          if (32'(clr_cnt) == COLS - 1) begin
            res      <= '{6'd0, 6'd0, 3'd0, 6'd0, hfsd_pkg::ST_OK, 1'b1};
            res_more <= 1'b0;
            clr_emit <= 1'b0;
            state    <= clr_emit ? S_EMIT : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/hfsd_span_mem.sv */
// Span store of the heightfield span direction flags unit.
// One write port and two registered read ports; depends on hfsd_pkg.
module hfsd_span_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  hfsd_pkg::span_entry_t wdata,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output hfsd_pkg::span_entry_t rdata_a,
  output hfsd_pkg::span_entry_t rdata_b
);

  hfsd_pkg::span_entry_t mem [DEPTH];

  // Write and read in the same clocked block; reads give the old entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* test/heightfield_span_direction_flags_unit_test.sv */
// Self-checking testbench for the heightfield span direction flags unit.
// Drives load, query and clear words and checks each result word against its own predictor.
// Depends on hfsd_pkg and heightfield_span_direction_flags_unit.
module heightfield_span_direction_flags_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int NSPAN = 8;
  localparam int DRAIN_CYCLES = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  hfsd_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hfsd_pkg::out_word_t out_word;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = hfsd_pkg::CFG_GRID_WIDTH;
  logic [15:0] cfg_data = '0;

  heightfield_span_direction_flags_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the span store and the registers.
  logic [12:0] sh_start [0:GX*GY*NSPAN-1];
  logic [12:0] sh_floor [0:GX*GY*NSPAN-1];
  logic [1:0]  sh_cls   [0:GX*GY*NSPAN-1];
  int          sh_fill  [0:GX*GY-1];
  int sh_w, sh_h, sh_clear, sh_steep, sh_flat;

  hfsd_pkg::out_word_t expected_words[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int queries_sent = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Generous bound on the whole run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int eff_w();
    return sh_w > GX ? GX : sh_w;
  endfunction

  function automatic int eff_h();
    return sh_h > GY ? GY : sh_h;
  endfunction

  function automatic int span_top(int col, int s);
    if (s + 1 < sh_fill[col]) return int'(sh_start[col*NSPAN + s + 1]);
    return int'(hfsd_pkg::TOP_LIMIT);
  endfunction

  // Class bits plus one open bit per direction for span s of column (x, y).
  function automatic logic [5:0] span_flags_of(int x, int y, int s);
    int col, cls, bottom, top, nx, ny, ncol, ncls, nb, nt, lo, hi, climb;
    bit open;
    logic [5:0] f;
    col = y*GX + x;
    cls = sh_cls[col*NSPAN + s];
    if (cls == int'(hfsd_pkg::CLS_NULL)) return '0;
    f = {4'b0000, cls[1:0]};
    bottom = sh_floor[col*NSPAN + s];
    top = span_top(col, s);
    for (int d = 0; d < 4; d++) begin
      nx = x + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
      ny = y + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
      open = 0;
      if (nx < 0 || ny < 0 || nx >= eff_w() || ny >= eff_h()) begin
        f[d+2] = 1'b1;
        continue;
      end
      ncol = ny*GX + nx;
      for (int k = 0; k < sh_fill[ncol]; k++) begin
        ncls = sh_cls[ncol*NSPAN + k];
        if (ncls == int'(hfsd_pkg::CLS_NULL)) begin
          open = 0;
          continue;
        end
        nb = sh_floor[ncol*NSPAN + k];
        nt = span_top(ncol, k);
        hi = top < nt ? top : nt;
        lo = bottom > nb ? bottom : nb;
        if (hi - lo >= sh_clear) begin
          climb = nb - bottom;
          if (cls[hfsd_pkg::CLS_STEEP_BIT] || ncls[hfsd_pkg::CLS_STEEP_BIT])
            open = climb <= sh_steep;
          else open = climb <= sh_flat;
          break;
        end
      end
      if (open) f[d+2] = 1'b1;
    end
    return f;
  endfunction

  // Update the shadow store and queue the result words of one accepted word.
  task automatic predict_word(hfsd_pkg::in_word_t w);
    int x, y, col, n;
    bit in_grid;
    hfsd_pkg::out_word_t r;
    x = w.cell_x;
    y = w.cell_y;
    col = y*GX + x;
    in_grid = x < eff_w() && y < eff_h();
    r = '0;
    r.out_x = w.cell_x;
    r.out_y = w.cell_y;
    r.last = 1'b1;
    case (w.opcode)
      hfsd_pkg::OP_CLEAR: begin
        foreach (sh_fill[i]) sh_fill[i] = 0;
        r = '0;
        r.last = 1'b1;
        expected_words.push_back(r);
      end
      hfsd_pkg::OP_LOAD: begin
        if (!in_grid || sh_fill[col] >= NSPAN) begin
          r.status = hfsd_pkg::ST_FULL;
        end else begin
          n = sh_fill[col];
          sh_start[col*NSPAN + n] = w.span_floor_start;
          sh_floor[col*NSPAN + n] = w.span_floor_end;
          sh_cls[col*NSPAN + n] = w.span_kind;
          sh_fill[col] = n + 1;
          r.slot = 3'(n);
          r.status = hfsd_pkg::ST_OK;
        end
        expected_words.push_back(r);
      end
      hfsd_pkg::OP_QUERY: begin
        if (!in_grid || sh_fill[col] == 0) begin
          r.status = hfsd_pkg::ST_EMPTY;
          expected_words.push_back(r);
        end else begin
          n = sh_fill[col];
          for (int i = 0; i < n; i++) begin
            r.slot = 3'(i);
            r.span_flags = span_flags_of(x, y, i);
            r.status = hfsd_pkg::ST_OK;
            r.last = (i == n - 1);
            expected_words.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word, at times with a random gap in front of it, and wait until it is taken.
  task automatic send_word(hfsd_pkg::in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    words_sent++;
    if (w.opcode == hfsd_pkg::OP_QUERY) queries_sent++;
  endtask

  // Stop offering words and wait until the block has delivered everything.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five registers on consecutive cycles; the block must be idle.
  task automatic set_config(int w, int h, int clr, int steep, int flat);
    int vals[5];
    logic [2:0] idx[5];
    vals = '{w, h, clr, steep, flat};
    idx = '{hfsd_pkg::CFG_GRID_WIDTH, hfsd_pkg::CFG_GRID_HEIGHT, hfsd_pkg::CFG_CLEARANCE,
            hfsd_pkg::CFG_STEEP_LIMIT, hfsd_pkg::CFG_FLAT_LIMIT};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 16'(vals[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    sh_w = w & 'h7f;
    sh_h = h & 'h7f;
    sh_clear = clr & 'hffff;
    sh_steep = steep & 'h1fff;
    sh_flat = flat & 'h1fff;
  endtask

  function automatic hfsd_pkg::in_word_t make_word(logic [1:0] op, int x, int y, int s, int f,
                                                   int k);
    hfsd_pkg::in_word_t w;
    w.opcode = op;
    w.cell_x = 6'(x);
    w.cell_y = 6'(y);
    w.span_floor_start = 13'(s);
    w.span_floor_end = 13'(f);
    w.span_kind = 2'(k);
    return w;
  endfunction

  // Receiver: random stall, long hold-offs on request, and the result check.
  always @(posedge clk) begin
    hfsd_pkg::out_word_t e;
    if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_request <= hold_request - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", out_word);
      end else begin
        e = expected_words.pop_front();
        if (out_word.out_x !== e.out_x || out_word.out_y !== e.out_y ||
            out_word.slot !== e.slot || out_word.span_flags !== e.span_flags ||
            out_word.status !== e.status || out_word.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, out_word);
        end
      end
    end
  end

  // Corners, class extremes, a full column, null spans, clear and the unused opcode.
  task automatic test_directed();
    send_word(make_word(hfsd_pkg::OP_QUERY, 0, 0, 0, 0, 0));
    send_word(make_word(hfsd_pkg::OP_LOAD, 0, 0, 0, 0, 1));
    send_word(make_word(hfsd_pkg::OP_LOAD, 0, 0, 20, 22, 2));
    send_word(make_word(hfsd_pkg::OP_LOAD, 0, 0, 60, 63, 0));
    send_word(make_word(hfsd_pkg::OP_LOAD, 1, 0, 0, 3, 1));
    send_word(make_word(hfsd_pkg::OP_LOAD, 1, 0, 30, 25, 3));
    send_word(make_word(hfsd_pkg::OP_QUERY, 0, 0, 0, 0, 0));
    send_word(make_word(hfsd_pkg::OP_QUERY, 1, 0, 0, 0, 0));
    send_word(make_word(hfsd_pkg::OP_LOAD, 63, 63, 8191, 8191, 3));
    send_word(make_word(hfsd_pkg::OP_QUERY, 63, 63, 0, 0, 0));
    for (int i = 0; i < NSPAN + 1; i++)
      send_word(make_word(hfsd_pkg::OP_LOAD, 5, 5, 100*i, 100*i + 50, i % 4));
    send_word(make_word(hfsd_pkg::OP_QUERY, 5, 5, 0, 0, 0));
    send_word(make_word(hfsd_pkg::OP_UNUSED, 63, 0, 8191, 0, 3));
    send_word(make_word(hfsd_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    send_word(make_word(hfsd_pkg::OP_QUERY, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Mostly ascending loads and queries around a small patch, with some noise.
  task automatic test_random(int count);
    int roll, x, y, col, s, f;
    logic [63:0] rnd;
    hfsd_pkg::in_word_t w;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if ($urandom_range(4) == 0) begin
        x = $urandom_range(63);
        y = $urandom_range(63);
      end else begin
        x = $urandom_range(3);
        y = $urandom_range(3);
        if ($urandom_range(3) == 0 && eff_w() > 0) x = eff_w() - 1 - $urandom_range(1);
        if (x < 0) x = 0;
      end
      col = y*GX + x;
      if (roll < 50) begin
        s = sh_fill[col] > 0 ? sh_floor[col*NSPAN + sh_fill[col] - 1] + $urandom_range(40) :
            $urandom_range(60);
        if (s > 8191) s = 8191;
        f = s + $urandom_range(30);
        if (f > 8191) f = 8191;
        w = make_word(hfsd_pkg::OP_LOAD, x, y, s, f, $urandom_range(3));
      end else if (roll < 85) begin
        w = make_word(hfsd_pkg::OP_QUERY, x, y, $urandom_range(8191), $urandom_range(8191), 0);
      end else if (roll < 88) begin
        w = make_word(hfsd_pkg::OP_CLEAR, $urandom_range(63), $urandom_range(63), 0, 0, 0);
      end else if (roll < 90) begin
        w = make_word(hfsd_pkg::OP_UNUSED, x, y, 0, 0, 0);
      end else begin
        rnd = {$urandom, $urandom};
        w = rnd[$bits(hfsd_pkg::in_word_t)-1:0];
        if (w.opcode == hfsd_pkg::OP_UNUSED) w.opcode = hfsd_pkg::OP_LOAD;
      end
      send_word(w);
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_backpressure();
    hold_request = 400;
    test_random(30);
  endtask

  initial begin
    foreach (sh_fill[i]) sh_fill[i] = 0;
    sh_w = 64; sh_h = 64; sh_clear = 16; sh_steep = 2; sh_flat = 4;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 19;
    recv_idle_pct = 72;
    test_directed();
    test_random(110);

    send_idle_pct = 72;
    recv_idle_pct = 19;
    set_config($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 40),
               $urandom_range(0, 20), $urandom_range(0, 20));
    test_random(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(127, 127, 0, 8191, 0);
    test_random(60);
    set_config(1, 64, 65535, 0, 8191);
    test_random(40);
    set_config(0, 0, 16, 2, 4);
    test_random(10);
    set_config(64, 64, 16, 2, 4);
    test_backpressure();
    set_config(4, 4, $urandom_range(0, 30), $urandom_range(0, 8), $urandom_range(0, 8));
    test_random(40);

    $display("Sent %0d input words (%0d queries) over seven register settings.",
             words_sent, queries_sent);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
